>>> rtl/srr_pkg.sv
// Shared types and constants for the sparse identifier run remapper.
// Holds the controller/datapath command and status structs and the default sizes.
// No dependencies.
package srr_pkg;

  localparam int ID_W          = 32;
  localparam int MAX_RUNS_DEF  = 512;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // capture the accepted item and restart the scan counter
    logic append;      // perform the append update and build its result
    logic scan_issue;  // read the run at the scan counter and advance it
    logic flush;       // drop scan reads still in flight
    logic res_hit;     // build a lookup-hit result from the compare stage
    logic res_miss;    // build a lookup-miss result
    logic emit;        // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;    // every stored run has been issued
    logic pipe_empty;  // no scan read in flight
    logic hit;         // the compare stage holds a matching run
    logic out_free;    // the output register can take a result this cycle
  } sts_t;

endpackage

>>> rtl/srr_ctrl.sv
// Controller state machine for the sparse identifier run remapper.
// Drives srr_pkg::cmd_t commands into srr_datapath from its srr_pkg::sts_t status.
// Depends on srr_pkg.
module srr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_op,
  output logic          in_tready,
  input  srr_pkg::sts_t sts,
  output srr_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_APPEND = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = in_op ? ST_SCAN : ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_SCAN: begin
        // The compare stage holds the oldest run in flight, so the first hit wins.
        priority if (sts.hit) begin
          cmd.res_hit = 1'b1;
          cmd.flush   = 1'b1;
          state_nxt   = ST_EMIT;
        end else if (sts.scan_end && sts.pipe_empty) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.scan_issue = !sts.scan_end;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan reads only live while a lookup is running.
  a_pipe_idle_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> sts.pipe_empty)
    else $error("scan pipeline busy outside a lookup");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_APPEND || state_r == ST_SCAN))
    else $error("accepted item did not start work");

endmodule

>>> rtl/srr_datapath.sv
// Datapath of the sparse identifier run remapper: run table memories, append
// update, pipelined lookup scan, result and output registers.
// Depends on srr_pkg.
module srr_datapath #(
  parameter int MAX_RUNS = srr_pkg::MAX_RUNS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  srr_pkg::cmd_t            cmd,
  output srr_pkg::sts_t            sts,
  input  logic [srr_pkg::ID_W-1:0] in_id,
  input  logic                     cfg_we,
  input  logic [srr_pkg::ID_W-1:0] cfg_data,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [srr_pkg::ID_W-1:0] out_dense,
  output logic                     out_found,
  output logic                     out_ovf
);

  localparam int W    = srr_pkg::ID_W;
  localparam int CntW = $clog2(MAX_RUNS + 1);
  localparam int IdxW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  // Run 0 lives in registers; the memories serve runs 1 and up.
  logic [2*W-1:0] mem_fb [MAX_RUNS];   // {base, first}
  logic [W-1:0]   mem_last [MAX_RUNS];

  logic [W-1:0]    base0_r;
  logic [W-1:0]    last0_r;
  logic            last0_ok_r;
  logic [W-1:0]    next_dense_r;
  logic [W-1:0]    previous_id_r;
  logic [CntW-1:0] run_count_r;
  logic            spill_r;
  logic            started_r;
  logic [W-1:0]    item_id_r;
  logic [CntW-1:0] scan_cnt_r;

  logic [2*W-1:0]  rd_fb_r;
  logic [W-1:0]    rd_last_r;
  logic            s1_v_r;
  logic            s1_zero_r;
  logic            s2_v_r;
  logic            s2_hit_r;
  logic [W-1:0]    s2_diff_r;
  logic [W-1:0]    s2_base_r;

  logic [W-1:0]    res_dense_r;
  logic            res_found_r;
  logic            res_ovf_r;
  logic            out_valid_r;
  logic [W-1:0]    out_dense_r;
  logic            out_found_r;
  logic            out_ovf_r;

  logic            follows;
  logic            has_room;
  logic            new_run;
  logic            ovf_now;
  logic [CntW-1:0] open_run;
  logic            open_is_zero;
  logic            fb_we;
  logic            last_we;
  logic [IdxW-1:0] last_idx;
  logic [IdxW-1:0] rd_addr;
  logic [W-1:0]    first_sel;
  logic [W-1:0]    last_sel;
  logic [W-1:0]    base_sel;
  logic            ok_sel;
  logic            match;

  // "Follows" is tested without wrap: an identifier of 0 after all ones opens a run.
  assign follows      = ({1'b0, previous_id_r} + {{W{1'b0}}, 1'b1}) == {1'b0, item_id_r};
  assign has_room     = run_count_r < CntW'(MAX_RUNS);
  assign new_run      = !follows && has_room;
  assign ovf_now      = !follows && !has_room;
  assign open_run     = run_count_r - CntW'(1);
  assign open_is_zero = open_run == '0;
  assign fb_we        = cmd.append && new_run;
  assign last_we      = cmd.append && (new_run || (follows && !spill_r && !open_is_zero));
  assign last_idx     = new_run ? run_count_r[IdxW-1:0] : open_run[IdxW-1:0];
  assign rd_addr      = scan_cnt_r[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (fb_we) begin
      mem_fb[run_count_r[IdxW-1:0]] <= {next_dense_r, item_id_r};
    end
    if (last_we) begin
      mem_last[last_idx] <= item_id_r;
    end
    rd_fb_r   <= mem_fb[rd_addr];
    rd_last_r <= mem_last[rd_addr];
  end

  // Run 0 has a fixed first identifier of 1 and no last identifier until written.
  assign first_sel = s1_zero_r ? W'(1) : rd_fb_r[W-1:0];
  assign base_sel  = s1_zero_r ? base0_r : rd_fb_r[2*W-1:W];
  assign last_sel  = s1_zero_r ? last0_r : rd_last_r;
  assign ok_sel    = s1_zero_r ? last0_ok_r : 1'b1;
  assign match     = ok_sel && (first_sel <= item_id_r) && (last_sel >= item_id_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base0_r       <= '0;
      last0_ok_r    <= 1'b0;
      next_dense_r  <= '0;
      previous_id_r <= '0;
      run_count_r   <= CntW'(1);
      spill_r       <= 1'b0;
      started_r     <= 1'b0;
      scan_cnt_r    <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      // The base only seeds run 0 and the dense counter before the first append.
      if (cfg_we) begin
        if (!started_r) begin
          base0_r      <= cfg_data;
          next_dense_r <= cfg_data;
        end
      end

      if (cmd.append) begin
        previous_id_r <= item_id_r;
        next_dense_r  <= next_dense_r + W'(1);
        started_r     <= 1'b1;
        if (follows && !spill_r && open_is_zero) begin
          last0_ok_r <= 1'b1;
        end
        if (new_run) begin
          run_count_r <= run_count_r + CntW'(1);
          spill_r     <= 1'b0;
        end else if (ovf_now) begin
          spill_r <= 1'b1;
        end
      end

      if (cmd.load_item) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_cnt_r <= scan_cnt_r + CntW'(1);
      end

      s1_v_r <= cmd.scan_issue && !cmd.flush;
      s2_v_r <= s1_v_r && !cmd.flush;

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_id_r <= in_id;
    end
    if (cmd.append && follows && !spill_r && open_is_zero) begin
      last0_r <= item_id_r;
    end
    s1_zero_r <= scan_cnt_r == '0;
    s2_hit_r  <= match;
    s2_diff_r <= item_id_r - first_sel;
    s2_base_r <= base_sel;

    // The controller raises at most one of these result commands per cycle.
    if (cmd.append) begin
      res_dense_r <= next_dense_r;
      res_found_r <= 1'b1;
      res_ovf_r   <= ovf_now;
    end else if (cmd.res_hit) begin
      res_dense_r <= s2_base_r + s2_diff_r;
      res_found_r <= 1'b1;
      res_ovf_r   <= 1'b0;
    end else if (cmd.res_miss) begin
      res_dense_r <= item_id_r;
      res_found_r <= 1'b0;
      res_ovf_r   <= 1'b0;
    end

    if (cmd.emit) begin
      out_dense_r <= res_dense_r;
      out_found_r <= res_found_r;
      out_ovf_r   <= res_ovf_r;
    end
  end

  assign sts.scan_end   = scan_cnt_r == run_count_r;
  assign sts.pipe_empty = !s1_v_r && !s2_v_r;
  assign sts.hit        = s2_v_r && s2_hit_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_dense  = out_dense_r;
  assign out_found  = out_found_r;
  assign out_ovf    = out_ovf_r;

  a_run_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run_count_r >= CntW'(1)) && (run_count_r <= CntW'(MAX_RUNS)))
    else $error("run count out of range");

  a_spill_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(spill_r) |-> (run_count_r == CntW'(MAX_RUNS)))
    else $error("run dropped while the table had room");

endmodule

>>> rtl/sparse_id_run_remapper_unit.sv
// Sparse identifier run remapper. Append items (tuser 0) take the next dense
// index and grow a table of runs of consecutive identifiers; lookup items
// (tuser 1) scan the stored runs in order and return base plus offset, or echo
// the identifier with found low on a miss. An append passes through the append
// and emit states before the next possible input transfer. A lookup reads one stored run
// per cycle from the run table memory until a hit or the end of the stored
// runs, so at most MAX_RUNS stored runs are read. The
// output register lets the next item be taken while a result waits.
// Depends on srr_pkg, srr_ctrl and srr_datapath.
module sparse_id_run_remapper_unit #(
  parameter int MAX_RUNS = srr_pkg::MAX_RUNS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [srr_pkg::ID_W-1:0] in_tdata,   // [31:0] item_id
  input  logic                     in_tuser,   // [0] op: 0 append, 1 lookup
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [srr_pkg::ID_W-1:0] out_tdata,  // [31:0] dense_index
  output logic [1:0]               out_tuser,  // [0] found, [1] overflow
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [srr_pkg::ID_W-1:0] cfg_data    // base_index
);

  srr_pkg::cmd_t cmd;
  srr_pkg::sts_t sts;
  logic          found;
  logic          ovf;

  // Configuration is to be written by the user only while the block is idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  srr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srr_datapath #(
    .MAX_RUNS (MAX_RUNS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_id      (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_dense  (out_tdata),
    .out_found  (found),
    .out_ovf    (ovf)
  );

  assign out_tuser = {ovf, found};

endmodule
